// ===== src/ad2i_pkg.sv =====
// Shared types, constants and the saturation helper for the 2D affine inverse core.
// Used by ad2i_div_lane and affine_2d_matrix_inverse_core; depends on nothing else.
`default_nettype none
package ad2i_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DIV_STEPS     = 32;
    // Lane latency: operand stage, one stage per quotient bit, round stage, clamp stage.
    localparam int LANE_LAT      = DIV_STEPS + 3;
    localparam int LANES         = 4;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } t_lane_res;

    typedef struct packed {
        logic               cmd;
        logic               sing;
        logic signed [31:0] tx;
        logic signed [31:0] ty;
    } t_side;

    localparam logic [64:0] NEG_LIMIT = 65'd2147483648;
    localparam logic [64:0] POS_LIMIT = 65'd2147483647;

    // Applies the sign to a rounded magnitude and clamps it to 32 signed bits.
    function automatic t_lane_res sat_q(input logic [64:0] mag, input logic over,
                                        input logic neg);
        t_lane_res res;
        logic [64:0] negm;
        negm = 65'd0 - mag;
        if (neg) begin
            res.sat = over || (mag > NEG_LIMIT);
            res.val = res.sat ? 32'sh8000_0000 : $signed(negm[31:0]);
        end else begin
            res.sat = over || (mag > POS_LIMIT);
            res.val = res.sat ? 32'sh7fff_ffff : $signed(mag[31:0]);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== src/ad2i_div_lane.sv =====
// Pipelined restoring divider lane: round(num * 2^(2F) / den), signed and saturated.
// One quotient bit per stage; depends on ad2i_pkg.
`default_nettype none
module ad2i_div_lane import ad2i_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [31:0] i_num,
    input  wire logic        i_neg,
    input  wire logic [63:0] i_den,
    output t_lane_res        o_res
);

    localparam int SH = 2 * FRAC_BITS;

    logic [95:0] w_dvd;
    assign w_dvd = {64'd0, i_num} << SH;

    logic [62:0] r_rem  [0:DIV_STEPS];
    logic [31:0] r_q    [0:DIV_STEPS];
    logic [31:0] r_lo   [0:DIV_STEPS-1];
    logic [63:0] r_den  [0:DIV_STEPS];
    logic        r_neg  [0:DIV_STEPS];
    logic        r_over [0:DIV_STEPS];

    // A quotient of 2^32 or more always saturates, so only 32 bits are developed.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_dvd[94:32];
            r_lo[0]   <= w_dvd[31:0];
            r_q[0]    <= 32'd0;
            r_den[0]  <= i_den;
            r_neg[0]  <= i_neg;
            r_over[0] <= (w_dvd[95:32] >= i_den);
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic [63:0] w_try;
            logic [63:0] w_diff;
            logic        w_ge;
            assign w_try  = {r_rem[k], r_lo[k][31]};
            assign w_ge   = (w_try >= r_den[k]);
            assign w_diff = w_try - r_den[k];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1]  <= w_ge ? w_diff[62:0] : w_try[62:0];
                    r_q[k+1]    <= {r_q[k][30:0], w_ge};
                    r_den[k+1]  <= r_den[k];
                    r_neg[k+1]  <= r_neg[k];
                    r_over[k+1] <= r_over[k];
                end
            end
            if (k + 1 < DIV_STEPS) begin : g_lo
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_lo[k+1] <= {r_lo[k][30:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    logic [32:0] r_qr;
    logic        r_neg_r;
    logic        r_over_r;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_qr     <= {1'b0, r_q[DIV_STEPS]} +
                        33'(({r_rem[DIV_STEPS], 1'b0} >= r_den[DIV_STEPS]) ? 1 : 0);
            r_neg_r  <= r_neg[DIV_STEPS];
            r_over_r <= r_over[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= sat_q({32'd0, r_qr}, r_over_r, r_neg_r);
        end
    end

endmodule
`default_nettype wire

// ===== src/affine_2d_matrix_inverse_core.sv =====
// One input transaction is accepted every cycle while the output flows.
// Most of the pipeline lies in the divider lanes: 32 quotient stages, one quotient bit per stage.
// A stall at the output holds the whole pipeline. Reset clears only the valid bits,
// and no transaction is accepted while reset is held.
// Top level of the 2D affine inverse core; depends on ad2i_pkg and ad2i_div_lane.
`default_nettype none
module affine_2d_matrix_inverse_core import ad2i_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [191:0] s_axis_tdata,  // m00, m01, m10, m11, tx, ty
    input  wire logic [0:0]   s_axis_tuser,  // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [191:0]      m_axis_tdata,  // inv_00, inv_01, inv_10, inv_11, inv_tx, inv_ty
    output logic [1:0]        m_axis_tuser   // singular, saturated
);

    localparam int DEPTH = LANE_LAT + 7;

    logic             w_en;
    logic [DEPTH-1:0] r_vld;

    assign w_en          = !r_vld[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = w_en && i_rst_n;
    assign m_axis_tvalid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], s_axis_tvalid};
        end
    end

    logic signed [31:0] w_m00, w_m01, w_m10, w_m11;
    logic signed [31:0] w_v [0:LANES-1];
    logic               w_f [0:LANES-1];
    t_side              w_side;

    assign w_m00 = $signed(s_axis_tdata[31:0]);
    assign w_m01 = $signed(s_axis_tdata[63:32]);
    assign w_m10 = $signed(s_axis_tdata[95:64]);
    assign w_m11 = $signed(s_axis_tdata[127:96]);
    assign w_side.cmd  = s_axis_tuser[0];
    assign w_side.sing = 1'b0;
    assign w_side.tx   = $signed(s_axis_tdata[159:128]);
    assign w_side.ty   = $signed(s_axis_tdata[191:160]);

    // Lane numerators; the off-diagonal ones are negated and swap in transpose mode.
    assign w_v[0] = w_m11;
    assign w_f[0] = 1'b0;
    assign w_v[1] = w_side.cmd ? w_m10 : w_m01;
    assign w_f[1] = 1'b1;
    assign w_v[2] = w_side.cmd ? w_m01 : w_m10;
    assign w_f[2] = 1'b1;
    assign w_v[3] = w_m00;
    assign w_f[3] = 1'b0;

    logic signed [63:0] r1_pa, r1_pb, r2_det;
    logic [31:0]        r1_num [0:LANES-1];
    logic [31:0]        r2_num [0:LANES-1];
    logic [31:0]        r3_num [0:LANES-1];
    logic               r1_nneg [0:LANES-1];
    logic               r2_nneg [0:LANES-1];
    logic               r3_neg  [0:LANES-1];
    logic [63:0]        r3_den;
    t_side              r1_side, r2_side, r3_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pa   <= w_m00 * w_m11;
            r1_pb   <= w_m10 * w_m01;
            r1_side <= w_side;
            r2_det  <= r1_pa - r1_pb;
            r2_side <= r1_side;
            r3_den  <= r2_det[63] ? 64'd0 - r2_det : r2_det;
            r3_side <= {r2_side.cmd, (r2_det == 64'sd0), r2_side.tx, r2_side.ty};
        end
    end

    genvar j;
    t_lane_res w_res [0:LANES-1];
    generate
        for (j = 0; j < LANES; j++) begin : g_lane
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r1_num[j]  <= w_v[j][31] ? 32'd0 - w_v[j] : w_v[j];
                    r1_nneg[j] <= w_f[j] ? (!w_v[j][31] && (w_v[j] != 32'sd0)) : w_v[j][31];
                    r2_num[j]  <= r1_num[j];
                    r2_nneg[j] <= r1_nneg[j];
                    r3_num[j]  <= r2_num[j];
                    r3_neg[j]  <= r2_nneg[j] ^ r2_det[63];
                end
            end
            ad2i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_num (r3_num[j]),
                .i_neg (r3_neg[j]),
                .i_den (r3_den),
                .o_res (w_res[j])
            );
        end
    endgenerate

    t_side r_dl [0:LANE_LAT-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dl[0] <= r3_side;
            for (int i = 1; i < LANE_LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    logic signed [63:0] r4_p [0:LANES-1];
    logic signed [31:0] r4_r [0:LANES-1];
    logic signed [31:0] r5_r [0:LANES-1];
    logic signed [31:0] r6_r [0:LANES-1];
    logic               r4_sat, r5_sat, r6_sat;
    t_side              r4_side, r5_side, r6_side;
    logic signed [64:0] r5_s [0:1];
    logic [64:0]        r6_m [0:1];
    logic               r6_neg [0:1];

    localparam logic [64:0] HALF = 65'd1 << (FRAC_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_p[0] <= r_dl[LANE_LAT-1].tx * w_res[0].val;
            r4_p[1] <= r_dl[LANE_LAT-1].ty * w_res[2].val;
            r4_p[2] <= r_dl[LANE_LAT-1].tx * w_res[1].val;
            r4_p[3] <= r_dl[LANE_LAT-1].ty * w_res[3].val;
            for (int i = 0; i < LANES; i++) begin
                r4_r[i] <= w_res[i].val;
                r5_r[i] <= r4_r[i];
                r6_r[i] <= r5_r[i];
            end
            r4_sat  <= w_res[0].sat | w_res[1].sat | w_res[2].sat | w_res[3].sat;
            r4_side <= r_dl[LANE_LAT-1];
            r5_s[0] <= -{r4_p[0][63], r4_p[0]} - {r4_p[1][63], r4_p[1]};
            r5_s[1] <= -{r4_p[2][63], r4_p[2]} - {r4_p[3][63], r4_p[3]};
            r5_sat  <= r4_sat;
            r5_side <= r4_side;
            for (int i = 0; i < 2; i++) begin
                r6_m[i]   <= ((r5_s[i][64] ? 65'd0 - r5_s[i] : r5_s[i]) + HALF) >> FRAC_BITS;
                r6_neg[i] <= r5_s[i][64];
            end
            r6_sat  <= r5_sat;
            r6_side <= r5_side;
        end
    end

    t_lane_res w_tx, w_ty;
    assign w_tx = sat_q(r6_m[0], 1'b0, r6_neg[0]);
    assign w_ty = sat_q(r6_m[1], 1'b0, r6_neg[1]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r6_side.sing) begin
                m_axis_tdata <= '0;
                m_axis_tuser <= 2'b01;
            end else if (r6_side.cmd) begin
                m_axis_tdata <= {r6_side.ty, r6_side.tx, r6_r[3], r6_r[2], r6_r[1], r6_r[0]};
                m_axis_tuser <= {r6_sat, 1'b0};
            end else begin
                m_axis_tdata <= {w_ty.val, w_tx.val, r6_r[3], r6_r[2], r6_r[1], r6_r[0]};
                m_axis_tuser <= {r6_sat | w_tx.sat | w_ty.sat, 1'b0};
            end
        end
    end

endmodule
`default_nettype wire
